### rtl/lavm_pkg.sv
`default_nettype none
package lavm_pkg;

   localparam int DEF_COORD_WIDTH = 32;
   localparam int DEF_FRAC_BITS   = 16;

   // Depth of the queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;

   // Normalization brings the largest magnitude into [2^(SCALE_BITS-1), 2^SCALE_BITS).
   localparam int SCALE_BITS = 30;

   // Width of the step counter of the back part.
   localparam int CNT_W = 6;

   function automatic logic [1:0] next_axis(input logic [1:0] axis);
      return (axis == 2'd2) ? 2'd0 : axis + 2'd1;
   endfunction

endpackage
`default_nettype wire

### rtl/lavm_front.sv
`default_nettype none
module lavm_front
   import lavm_pkg::*;
#(
   parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic signed [COORD_WIDTH-1:0]  req_eye_x,
   input  logic signed [COORD_WIDTH-1:0]  req_eye_y,
   input  logic signed [COORD_WIDTH-1:0]  req_eye_z,
   input  logic signed [COORD_WIDTH-1:0]  req_aim_x,
   input  logic signed [COORD_WIDTH-1:0]  req_aim_y,
   input  logic signed [COORD_WIDTH-1:0]  req_aim_z,
   input  logic signed [COORD_WIDTH-1:0]  req_upward_x,
   input  logic signed [COORD_WIDTH-1:0]  req_upward_y,
   input  logic signed [COORD_WIDTH-1:0]  req_upward_z,
   output logic                           push,
   output logic [9*COORD_WIDTH+2:0]       push_data,
   input  logic                           full
);

   localparam int W  = COORD_WIDTH;
   localparam int DW = 9 * W + 3;

   logic              valid_ff;
   logic [DW-1:0]     data_ff;
   logic              accept;
   logic signed [W:0] dir_x;
   logic signed [W:0] dir_y;
   logic signed [W:0] dir_z;

   // The forward direction is formed here so that the back part starts on it at once.
   assign dir_x = (W+1)'(req_aim_x) - (W+1)'(req_eye_x);
   assign dir_y = (W+1)'(req_aim_y) - (W+1)'(req_eye_y);
   assign dir_z = (W+1)'(req_aim_z) - (W+1)'(req_eye_z);

   assign busy      = valid_ff & full;
   assign accept    = start & ~busy;
   assign push      = valid_ff & ~full;
   assign push_data = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (accept) begin
         valid_ff <= 1'b1;
      end else if (push) begin
         valid_ff <= 1'b0;
      end
      if (accept) begin
         data_ff <= {req_upward_z, req_upward_y, req_upward_x,
                     dir_z, dir_y, dir_x,
                     req_eye_z, req_eye_y, req_eye_x};
      end
   end

endmodule
`default_nettype wire

### rtl/lavm_queue.sv
`default_nettype none
module lavm_queue
   import lavm_pkg::*;
#(
   parameter int DATA_WIDTH = 8,
   parameter int DEPTH      = QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [DATA_WIDTH-1:0] push_data,
   output logic                  full,
   input  logic                  pop,
   output logic                  valid,
   output logic [DATA_WIDTH-1:0] data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_QW = $clog2(DEPTH + 1);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff;
   logic [PTR_W-1:0]      rd_ptr_ff;
   logic [CNT_QW-1:0]     count_ff;

   assign full  = (count_ff == CNT_QW'(DEPTH));
   assign valid = (count_ff != '0);
   assign data  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

### rtl/lavm_back.sv
`default_nettype none
module lavm_back
   import lavm_pkg::*;
#(
   parameter int COORD_WIDTH = DEF_COORD_WIDTH,
   parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  logic [9*COORD_WIDTH+2:0]      q_data,
   output logic                          q_pop,
   output logic                          rsp_strobe,
   output logic [1:0]                    rsp_column_index,
   output logic signed [COORD_WIDTH-1:0] rsp_row0,
   output logic signed [COORD_WIDTH-1:0] rsp_row1,
   output logic signed [COORD_WIDTH-1:0] rsp_row2,
   output logic [FRAC_BITS:0]            rsp_row3,
   output logic                          rsp_last,
   output logic                          rsp_degenerate
);

   localparam int W     = COORD_WIDTH;
   localparam int F     = FRAC_BITS;
   localparam int VW    = (W + 1 > F + 34) ? W + 1 : F + 34;
   localparam int UW    = F + 2;
   localparam int MW    = (UW > SCALE_BITS + 1) ? UW : SCALE_BITS + 1;
   localparam int PW    = 2 * MW;
   localparam int ACC_W = (F + W + 6 > 64) ? F + W + 6 : 64;
   localparam int ES    = W / 2;
   localparam int EHW   = W - ES;
   localparam int QB    = UW;
   localparam int LEN_W = SCALE_BITS + 1;
   localparam int RW    = SCALE_BITS + 2;
   localparam int NW    = SCALE_BITS + F + 1;
   localparam int RT_W  = 64;

   localparam logic signed [ACC_W-1:0] SAT_MAX = {{(ACC_W-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;
   localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(1) <<< (F - 1);
   localparam logic [VW-1:0]           LIM_HI  = VW'(1) << SCALE_BITS;
   localparam logic [VW-1:0]           LIM_LO  = VW'(1) << (SCALE_BITS - 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_MAG, ST_SHIFT, ST_SQ, ST_ROOT, ST_DIVSET, ST_DIV, ST_DIVEND,
      ST_XS, ST_XU, ST_DOT, ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      PH_F, PH_UP, PH_S
   } phase_type;

   state_type                state_ff;
   phase_type                phase_ff;
   logic [CNT_W-1:0]         k_ff;
   logic [1:0]               comp_ff;
   logic signed [W-1:0]      eye_ff [3];
   logic signed [W-1:0]      up_ff [3];
   logic signed [VW-1:0]     vec_ff [3];
   logic [VW-1:0]            mag_ff [3];
   logic [2:0]               neg_ff;
   logic signed [UW-1:0]     f_ff [3];
   logic signed [UW-1:0]     s_ff [3];
   logic signed [UW-1:0]     u_ff [3];
   logic signed [MW-1:0]     upn_ff [3];
   logic                     fok_ff;
   logic                     sok_ff;
   logic [RT_W-1:0]          root_n_ff;
   logic [RT_W-1:0]          root_res_ff;
   logic [RT_W-1:0]          root_bit_ff;
   logic [RW-1:0]            rem_ff;
   logic [QB-1:0]            quo_ff;
   logic signed [W-1:0]      dot_ff [3];
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [PW-1:0]     prod_ff;
   logic                     mul_valid_ff;
   logic                     mul_neg_ff;
   logic                     mul_shift_ff;
   logic                     rsp_strobe_ff;
   logic [1:0]               rsp_column_index_ff;
   logic signed [W-1:0]      rsp_row0_ff;
   logic signed [W-1:0]      rsp_row1_ff;
   logic signed [W-1:0]      rsp_row2_ff;
   logic [F:0]               rsp_row3_ff;
   logic                     rsp_last_ff;
   logic                     rsp_degenerate_ff;

   logic [VW-1:0]            mx;
   logic                     issue;
   logic signed [MW-1:0]     op_a;
   logic signed [MW-1:0]     op_b;
   logic                     op_neg;
   logic                     op_shift;
   logic [1:0]               ax1;
   logic [1:0]               ax2;
   logic [1:0]               di;
   logic [1:0]               ci;
   logic signed [EHW-1:0]    eye_hi;
   logic signed [ES:0]       eye_lo;
   logic signed [UW-1:0]     row_sel;
   logic signed [ACC_W-1:0]  term;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  rnd;
   logic signed [W:0]        dir_w [3];
   logic [NW-1:0]            num;
   logic [RW:0]              trial;
   logic                     trial_ge;
   logic [LEN_W-1:0]         len;
   logic [RT_W-1:0]          root_try;

   function automatic logic signed [W-1:0] sat_w(input logic signed [ACC_W-1:0] v);
      if (v > SAT_MAX) begin
         return SAT_MAX[W-1:0];
      end else if (v < SAT_MIN) begin
         return SAT_MIN[W-1:0];
      end
      return v[W-1:0];
   endfunction

   assign q_pop = (state_ff == ST_IDLE) & q_valid;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dir_w[i] = q_data[3*W + i*(W+1) +: W+1];
      end
   end

   always_comb begin
      mx = mag_ff[0];
      if (mag_ff[1] > mx) begin
         mx = mag_ff[1];
      end
      if (mag_ff[2] > mx) begin
         mx = mag_ff[2];
      end
   end

   assign len      = root_res_ff[LEN_W-1:0];
   assign num      = {mag_ff[comp_ff][SCALE_BITS-1:0], {F{1'b0}}} + NW'(len >> 1);
   assign trial    = {rem_ff, quo_ff[QB-1]};
   assign trial_ge = (trial >= (RW+1)'(len));
   assign root_try = root_res_ff + root_bit_ff;
   assign rnd      = (acc_ff + HALF) >>> F;
   assign ci       = (k_ff[1:0] == 2'd3) ? 2'd2 : k_ff[1:0];
   assign di       = (k_ff[2:1] == 2'd3) ? 2'd2 : k_ff[2:1];
   assign ax1      = next_axis(comp_ff);
   assign ax2      = next_axis(ax1);
   assign eye_hi   = eye_ff[di][W-1:ES];
   assign eye_lo   = {1'b0, eye_ff[di][ES-1:0]};

   always_comb begin
      case (comp_ff)
         2'd0:    row_sel = s_ff[di];
         2'd1:    row_sel = u_ff[di];
         default: row_sel = f_ff[di];
      endcase
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      issue    = 1'b0;
      op_a     = '0;
      op_b     = '0;
      op_neg   = 1'b0;
      op_shift = 1'b0;
      unique case (state_ff)
         ST_SQ: begin
            if (k_ff < CNT_W'(3)) begin
               issue = 1'b1;
               op_a  = MW'({1'b0, mag_ff[ci][SCALE_BITS-1:0]});
               op_b  = MW'({1'b0, mag_ff[ci][SCALE_BITS-1:0]});
            end
         end
         ST_XS: begin
            if (k_ff < CNT_W'(2)) begin
               issue  = 1'b1;
               op_neg = k_ff[0];
               op_a   = k_ff[0] ? MW'(f_ff[ax2]) : MW'(f_ff[ax1]);
               op_b   = k_ff[0] ? upn_ff[ax1] : upn_ff[ax2];
            end
         end
         ST_XU: begin
            if (k_ff < CNT_W'(2)) begin
               issue  = 1'b1;
               op_neg = k_ff[0];
               op_a   = k_ff[0] ? MW'(s_ff[ax2]) : MW'(s_ff[ax1]);
               op_b   = k_ff[0] ? MW'(f_ff[ax1]) : MW'(f_ff[ax2]);
            end
         end
         ST_DOT: begin
            if (k_ff < CNT_W'(6)) begin
               issue    = 1'b1;
               op_shift = k_ff[0];
               op_a     = MW'(row_sel);
               op_b     = k_ff[0] ? MW'(eye_hi) : MW'(eye_lo);
            end
         end
         default: begin
            issue = 1'b0;
         end
      endcase
   end

   always_comb begin
      term = mul_shift_ff ? (ACC_W'(prod_ff) <<< ES) : ACC_W'(prod_ff);
      acc_in = acc_ff;
      if (mul_valid_ff) begin
         acc_in = mul_neg_ff ? acc_ff - term : acc_ff + term;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= PH_F;
         k_ff          <= '0;
         comp_ff       <= '0;
         mul_valid_ff  <= 1'b0;
         acc_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         mul_valid_ff  <= issue;
         mul_neg_ff    <= op_neg;
         mul_shift_ff  <= op_shift;
         prod_ff       <= op_a * op_b;
         acc_ff        <= acc_in;
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  for (int i = 0; i < 3; i++) begin
                     eye_ff[i] <= q_data[i*W +: W];
                     up_ff[i]  <= q_data[6*W + 3 + i*W +: W];
                     vec_ff[i] <= VW'(dir_w[i]);
                  end
                  phase_ff <= PH_F;
                  state_ff <= ST_MAG;
               end
            end
            ST_MAG: begin
               for (int i = 0; i < 3; i++) begin
                  neg_ff[i] <= vec_ff[i][VW-1];
                  mag_ff[i] <= vec_ff[i][VW-1] ? VW'(-vec_ff[i]) : VW'(vec_ff[i]);
               end
               state_ff <= ST_SHIFT;
            end
            ST_SHIFT: begin
               if (mx == '0) begin
                  // A zero vector normalizes to zero.
                  k_ff    <= '0;
                  comp_ff <= '0;
                  case (phase_ff)
                     PH_F: begin
                        for (int i = 0; i < 3; i++) begin
                           f_ff[i]   <= '0;
                           vec_ff[i] <= VW'(up_ff[i]);
                        end
                        fok_ff   <= 1'b0;
                        phase_ff <= PH_UP;
                        state_ff <= ST_MAG;
                     end
                     PH_UP: begin
                        for (int i = 0; i < 3; i++) begin
                           upn_ff[i] <= '0;
                        end
                        state_ff <= ST_XS;
                     end
                     default: begin
                        for (int i = 0; i < 3; i++) begin
                           s_ff[i] <= '0;
                        end
                        sok_ff   <= 1'b0;
                        state_ff <= ST_XU;
                     end
                  endcase
               end else if (mx >= LIM_HI) begin
                  for (int i = 0; i < 3; i++) begin
                     mag_ff[i] <= mag_ff[i] >> 1;
                  end
               end else if (mx < LIM_LO) begin
                  for (int i = 0; i < 3; i++) begin
                     mag_ff[i] <= mag_ff[i] << 1;
                  end
               end else if (phase_ff == PH_UP) begin
                  for (int i = 0; i < 3; i++) begin
                     upn_ff[i] <= neg_ff[i] ? -MW'({1'b0, mag_ff[i][SCALE_BITS-1:0]})
                                            : MW'({1'b0, mag_ff[i][SCALE_BITS-1:0]});
                  end
                  k_ff     <= '0;
                  comp_ff  <= '0;
                  state_ff <= ST_XS;
               end else begin
                  k_ff     <= '0;
                  state_ff <= ST_SQ;
               end
            end
            ST_SQ: begin
               if (k_ff == CNT_W'(4)) begin
                  root_n_ff   <= acc_ff[RT_W-1:0];
                  root_res_ff <= '0;
                  root_bit_ff <= RT_W'(1) << (RT_W - 2);
                  acc_ff      <= '0;
                  k_ff        <= '0;
                  state_ff    <= ST_ROOT;
               end else begin
                  k_ff <= k_ff + 1'b1;
               end
            end
            ST_ROOT: begin
               if (root_n_ff >= root_try) begin
                  root_n_ff   <= root_n_ff - root_try;
                  root_res_ff <= (root_res_ff >> 1) + root_bit_ff;
               end else begin
                  root_res_ff <= root_res_ff >> 1;
               end
               root_bit_ff <= root_bit_ff >> 2;
               if (root_bit_ff == RT_W'(1)) begin
                  comp_ff  <= '0;
                  state_ff <= ST_DIVSET;
               end
            end
            ST_DIVSET: begin
               rem_ff   <= RW'(num >> QB);
               quo_ff   <= num[QB-1:0];
               k_ff     <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               rem_ff <= trial_ge ? RW'(trial - (RW+1)'(len)) : RW'(trial);
               quo_ff <= {quo_ff[QB-2:0], trial_ge};
               k_ff   <= k_ff + 1'b1;
               if (k_ff == CNT_W'(QB - 1)) begin
                  state_ff <= ST_DIVEND;
               end
            end
            ST_DIVEND: begin
               if (phase_ff == PH_F) begin
                  f_ff[comp_ff] <= neg_ff[comp_ff] ? -UW'(quo_ff) : UW'(quo_ff);
               end else begin
                  s_ff[comp_ff] <= neg_ff[comp_ff] ? -UW'(quo_ff) : UW'(quo_ff);
               end
               k_ff <= '0;
               if (comp_ff == 2'd2) begin
                  comp_ff <= '0;
                  if (phase_ff == PH_F) begin
                     fok_ff <= 1'b1;
                     for (int i = 0; i < 3; i++) begin
                        vec_ff[i] <= VW'(up_ff[i]);
                     end
                     phase_ff <= PH_UP;
                     state_ff <= ST_MAG;
                  end else begin
                     sok_ff   <= 1'b1;
                     state_ff <= ST_XU;
                  end
               end else begin
                  comp_ff  <= comp_ff + 1'b1;
                  state_ff <= ST_DIVSET;
               end
            end
            ST_XS: begin
               if (k_ff == CNT_W'(3)) begin
                  vec_ff[comp_ff] <= acc_ff[VW-1:0];
                  acc_ff          <= '0;
                  k_ff            <= '0;
                  if (comp_ff == 2'd2) begin
                     comp_ff  <= '0;
                     phase_ff <= PH_S;
                     state_ff <= ST_MAG;
                  end else begin
                     comp_ff <= comp_ff + 1'b1;
                  end
               end else begin
                  k_ff <= k_ff + 1'b1;
               end
            end
            ST_XU: begin
               if (k_ff == CNT_W'(3)) begin
                  u_ff[comp_ff] <= rnd[UW-1:0];
                  acc_ff        <= '0;
                  k_ff          <= '0;
                  if (comp_ff == 2'd2) begin
                     comp_ff  <= '0;
                     state_ff <= ST_DOT;
                  end else begin
                     comp_ff <= comp_ff + 1'b1;
                  end
               end else begin
                  k_ff <= k_ff + 1'b1;
               end
            end
            ST_DOT: begin
               if (k_ff == CNT_W'(7)) begin
                  dot_ff[comp_ff] <= (comp_ff == 2'd2) ? sat_w(rnd) : sat_w(-rnd);
                  acc_ff          <= '0;
                  k_ff            <= '0;
                  if (comp_ff == 2'd2) begin
                     comp_ff  <= '0;
                     state_ff <= ST_EMIT;
                  end else begin
                     comp_ff <= comp_ff + 1'b1;
                  end
               end else begin
                  k_ff <= k_ff + 1'b1;
               end
            end
            ST_EMIT: begin
               rsp_strobe_ff       <= 1'b1;
               rsp_column_index_ff <= k_ff[1:0];
               rsp_degenerate_ff   <= ~(fok_ff & sok_ff);
               if (k_ff[1:0] == 2'd3) begin
                  rsp_row0_ff <= dot_ff[0];
                  rsp_row1_ff <= dot_ff[1];
                  rsp_row2_ff <= dot_ff[2];
                  rsp_row3_ff <= (F+1)'(1) << F;
                  rsp_last_ff <= 1'b1;
                  k_ff        <= '0;
                  state_ff    <= ST_IDLE;
               end else begin
                  rsp_row0_ff <= sat_w(ACC_W'(s_ff[ci]));
                  rsp_row1_ff <= sat_w(ACC_W'(u_ff[ci]));
                  rsp_row2_ff <= sat_w(-ACC_W'(f_ff[ci]));
                  rsp_row3_ff <= '0;
                  rsp_last_ff <= 1'b0;
                  k_ff        <= k_ff + 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_column_index = rsp_column_index_ff;
   assign rsp_row0         = rsp_row0_ff;
   assign rsp_row1         = rsp_row1_ff;
   assign rsp_row2         = rsp_row2_ff;
   assign rsp_row3         = rsp_row3_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_degenerate   = rsp_degenerate_ff;

endmodule
`default_nettype wire

### rtl/look_at_view_matrix_core.sv
`default_nettype none
// Look-at view matrix: one camera pose (eye, aim point, up direction, signed fixed point)
// in, four column transactions out, column 0 first, the last one flagged by rsp_last.
// A pose is taken when start is high and busy is low; a two-entry queue behind the input
// stage lets up to three poses be held while one is computed. A pose takes less time
// when the forward or up vector is zero. The time of a pose is set by the shared multiplier,
// the one-bit-a-step normalizing shifter, the 32-step square root and the bit-serial divider;
// the shifter runs for the forward, up and side vectors, the root and divider for the
// forward and side vectors. Results appear on rsp_strobe for one cycle each, back to
// back, and the receiver cannot stall them.
module look_at_view_matrix_core
   import lavm_pkg::*;
#(
   parameter int COORD_WIDTH = DEF_COORD_WIDTH,
   parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_eye_x,
   input  logic signed [COORD_WIDTH-1:0] req_eye_y,
   input  logic signed [COORD_WIDTH-1:0] req_eye_z,
   input  logic signed [COORD_WIDTH-1:0] req_aim_x,
   input  logic signed [COORD_WIDTH-1:0] req_aim_y,
   input  logic signed [COORD_WIDTH-1:0] req_aim_z,
   input  logic signed [COORD_WIDTH-1:0] req_upward_x,
   input  logic signed [COORD_WIDTH-1:0] req_upward_y,
   input  logic signed [COORD_WIDTH-1:0] req_upward_z,
   output logic                          rsp_strobe,
   output logic [1:0]                    rsp_column_index,
   output logic signed [COORD_WIDTH-1:0] rsp_row0,
   output logic signed [COORD_WIDTH-1:0] rsp_row1,
   output logic signed [COORD_WIDTH-1:0] rsp_row2,
   output logic [FRAC_BITS:0]            rsp_row3,
   output logic                          rsp_last,
   output logic                          rsp_degenerate
);

   localparam int DW = 9 * COORD_WIDTH + 3;

   logic          push;
   logic [DW-1:0] push_data;
   logic          full;
   logic          q_valid;
   logic [DW-1:0] q_data;
   logic          q_pop;

   lavm_front #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_eye_x    (req_eye_x),
      .req_eye_y    (req_eye_y),
      .req_eye_z    (req_eye_z),
      .req_aim_x    (req_aim_x),
      .req_aim_y    (req_aim_y),
      .req_aim_z    (req_aim_z),
      .req_upward_x (req_upward_x),
      .req_upward_y (req_upward_y),
      .req_upward_z (req_upward_z),
      .push         (push),
      .push_data    (push_data),
      .full         (full)
   );

   lavm_queue #(
      .DATA_WIDTH (DW),
      .DEPTH      (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (q_pop),
      .valid     (q_valid),
      .data      (q_data)
   );

   lavm_back #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_data           (q_data),
      .q_pop            (q_pop),
      .rsp_strobe       (rsp_strobe),
      .rsp_column_index (rsp_column_index),
      .rsp_row0         (rsp_row0),
      .rsp_row1         (rsp_row1),
      .rsp_row2         (rsp_row2),
      .rsp_row3         (rsp_row3),
      .rsp_last         (rsp_last),
      .rsp_degenerate   (rsp_degenerate)
   );

endmodule
`default_nettype wire
